// ----- rtl/core/lts_pkg.sv -----
package lts_pkg;

  // Entry word: in-use bit, then flag, group, device address, ls3.
  localparam int ENTRY_W    = 49;
  localparam int USED_BIT   = 48;
  localparam int CTL_BIT    = 46;  // controller bit of the stored flag byte
  localparam int IN_USE_BIT = 7;   // in-use bit of a request's flag byte

  localparam logic [11:0] TOP_ADDRESS = 12'hfff;
  localparam logic [9:0]  NO_SLOT     = 10'd512;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FIND  = 2'd2;

  localparam logic [2:0] RES_MATCH = 3'd0;
  localparam logic [2:0] RES_GAP   = 3'd1;
  localparam logic [2:0] RES_AFTER = 3'd2;
  localparam logic [2:0] RES_FULL  = 3'd3;
  localparam logic [2:0] RES_DONE  = 3'd4;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SCAN,
    ST_POST
  } state_t;

  typedef struct packed {
    logic [23:0] device_addr;
    logic [7:0]  group;
    logic [7:0]  ls3;
    logic        is_controller;
  } query_t;

  typedef struct packed {
    logic [11:0] link_address;
    logic [9:0]  chosen_slot;
    logic [2:0]  outcome;
  } result_t;

  function automatic logic [11:0] slot_address(input logic [9:0] slot);
    logic [11:0] off;
    off = {slot[8:0], 3'b000};
    return TOP_ADDRESS - off;
  endfunction

endpackage

// ----- rtl/core/lts_mem.sv -----
module lts_mem #(
  parameter int SLOT_COUNT = 512
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(SLOT_COUNT)-1:0]   waddr,
  input  logic [lts_pkg::ENTRY_W-1:0]     wdata,
  input  logic                            re,
  input  logic [$clog2(SLOT_COUNT)-1:0]   raddr,
  output logic [lts_pkg::ENTRY_W-1:0]     rdata
);

  logic [lts_pkg::ENTRY_W-1:0] mem [SLOT_COUNT];
  logic [lts_pkg::ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lts_scan.sv -----
module lts_scan #(
  parameter int SLOT_COUNT = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            active,
  input  lts_pkg::query_t                 query,
  output logic                            re,
  output logic [$clog2(SLOT_COUNT)-1:0]   raddr,
  input  logic [lts_pkg::ENTRY_W-1:0]     rdata,
  output logic                            done,
  output lts_pkg::result_t                result
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam logic [SW:0]   COUNT_C = (SW+1)'(SLOT_COUNT);
  localparam logic [SW-1:0] LAST_C  = SW'(SLOT_COUNT - 1);

  logic [SW:0]   rd_idx_r, rd_idx_nxt;
  logic          rd_valid_r, rd_valid_nxt;
  logic [SW-1:0] ev_idx_r, ev_idx_nxt;
  logic [SW:0]   next_r, next_nxt;
  logic          gap_seen_r, gap_seen_nxt;
  logic [SW-1:0] gap_slot_r, gap_slot_nxt;

  logic          issue;
  logic          eval;
  logic          used;
  logic          hit;
  logic [SW:0]   ev_ext;
  logic [7:0]    e_grp;
  logic [23:0]   e_dev;
  logic [7:0]    e_l3;
  logic          e_ctl;

  assign issue = active && (rd_idx_r < COUNT_C);
  assign re    = issue;
  assign raddr = rd_idx_r[SW-1:0];
  assign eval  = active && rd_valid_r;

  assign used   = rdata[lts_pkg::USED_BIT];
  assign e_ctl  = rdata[lts_pkg::CTL_BIT];
  assign e_grp  = rdata[39:32];
  assign e_dev  = rdata[31:8];
  assign e_l3   = rdata[7:0];
  assign ev_ext = (SW+1)'(ev_idx_r);

  assign hit = eval && used && (e_dev == query.device_addr) && (e_grp == query.group) &&
               (e_ctl == query.is_controller) &&
               (query.is_controller || (query.ls3 == 8'd0) || (query.ls3 == e_l3));

  always_comb begin
    rd_idx_nxt   = rd_idx_r;
    rd_valid_nxt = issue;
    ev_idx_nxt   = ev_idx_r;
    next_nxt     = next_r;
    gap_seen_nxt = gap_seen_r;
    gap_slot_nxt = gap_slot_r;
    if (start) begin
      rd_idx_nxt   = '0;
      rd_valid_nxt = 1'b0;
      next_nxt     = '0;
      gap_seen_nxt = 1'b0;
      gap_slot_nxt = '0;
    end else begin
      if (issue) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
        ev_idx_nxt = rd_idx_r[SW-1:0];
      end
      if (eval && used) begin
        // an empty run before this used slot is a gap
        if (ev_ext != next_r) begin
          gap_seen_nxt = 1'b1;
          gap_slot_nxt = next_r[SW-1:0];
        end
        next_nxt = ev_ext + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      rd_valid_r <= 1'b0;
      ev_idx_r   <= '0;
      next_r     <= '0;
      gap_seen_r <= 1'b0;
      gap_slot_r <= '0;
    end else begin
      rd_idx_r   <= rd_idx_nxt;
      rd_valid_r <= rd_valid_nxt;
      ev_idx_r   <= ev_idx_nxt;
      next_r     <= next_nxt;
      gap_seen_r <= gap_seen_nxt;
      gap_slot_r <= gap_slot_nxt;
    end
  end

  assign done = eval && (hit || (ev_idx_r == LAST_C));

  always_comb begin
    result = '0;
    if (hit) begin
      result.chosen_slot = 10'(ev_idx_r);
      result.outcome     = lts_pkg::RES_MATCH;
    end else if (gap_seen_nxt) begin
      result.chosen_slot = 10'(gap_slot_nxt);
      result.outcome     = lts_pkg::RES_GAP;
    end else if (next_nxt == COUNT_C) begin
      result.chosen_slot = lts_pkg::NO_SLOT;
      result.outcome     = lts_pkg::RES_FULL;
    end else begin
      result.chosen_slot = 10'(next_nxt);
      result.outcome     = lts_pkg::RES_AFTER;
    end
    if (result.outcome != lts_pkg::RES_FULL) begin
      result.link_address = lts_pkg::slot_address(result.chosen_slot);
    end
  end

endmodule

// ----- rtl/core/link_table_slot_finder.sv -----
// Link table slot finder.
// Requests enter on the in_ channel (tuser = opcode) and one result per request
// leaves on the out_ channel (tuser = outcome). The slot table lives in a single
// one-read, one-write memory of SLOT_COUNT entries, each holding an in-use bit
// and the stored link record.
// Behaviour, one request at a time:
//   write (or reserved opcode): any table write happens on accept, then the result is posted.
//   clear: one entry emptied per cycle.
//   find: the walk reads one slot per cycle through the memory read port and
//         stops at the first matching entry or at the last slot.
//   Each result then moves through ST_POST into the output register once it is free.
// After reset the same emptying sweep runs with in_tready low; no result is
// produced for it.
// A result waiting on out_tready stays in the output register; the block still
// accepts the next request, and holds that request's result until the output
// register frees up.
module link_table_slot_finder #(
  parameter int SLOT_COUNT = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // slot[8:0], link_flag[16:9], group[24:17], device_addr[48:25], ls3[56:49],
  // is_controller[57], zero fill[63:58]
  input  logic [63:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // link_address[11:0], chosen_slot[21:12], zero fill[23:22]
  output logic [23:0] out_tdata,
  // outcome[2:0]
  output logic [2:0]  out_tuser
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam logic [SW-1:0] LAST_C  = SW'(SLOT_COUNT - 1);
  localparam logic [9:0]    COUNT_C = 10'(SLOT_COUNT);

  lts_pkg::state_t  state_r, state_nxt;
  logic             sweep_rsp_r, sweep_rsp_nxt;
  logic [SW-1:0]    sw_r, sw_nxt;
  lts_pkg::query_t  q_r, q_nxt;
  lts_pkg::result_t res_r, res_nxt;
  lts_pkg::result_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_acc;
  logic             load;
  logic             sweep_end;
  logic             slot_ok;
  logic [1:0]       opcode;
  logic [8:0]       in_slot;
  logic [7:0]       in_flag;

  logic                    mem_we;
  logic [SW-1:0]           mem_waddr;
  logic [lts_pkg::ENTRY_W-1:0] mem_wdata;
  logic                    mem_re;
  logic [SW-1:0]           mem_raddr;
  logic [lts_pkg::ENTRY_W-1:0] mem_rdata;

  logic             scan_start;
  logic             scan_active;
  logic             scan_done;
  lts_pkg::result_t scan_res;

  assign opcode  = in_tuser;
  assign in_slot = in_tdata[8:0];
  assign in_flag = in_tdata[16:9];
  assign in_acc  = in_tvalid && in_tready;
  assign slot_ok = {1'b0, in_slot} < COUNT_C;
  assign sweep_end = (state_r == lts_pkg::ST_SWEEP) && (sw_r == LAST_C);
  assign load    = (state_r == lts_pkg::ST_POST) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lts_pkg::ST_SWEEP: begin
        if (sweep_end) begin
          state_nxt = sweep_rsp_r ? lts_pkg::ST_POST : lts_pkg::ST_IDLE;
        end
      end
      lts_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (opcode)
            lts_pkg::OP_CLEAR: state_nxt = lts_pkg::ST_SWEEP;
            lts_pkg::OP_FIND:  state_nxt = lts_pkg::ST_SCAN;
            default:           state_nxt = lts_pkg::ST_POST;
          endcase
        end
      end
      lts_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = lts_pkg::ST_POST;
        end
      end
      lts_pkg::ST_POST: begin
        if (load) begin
          state_nxt = lts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lts_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_tready     = (state_r == lts_pkg::ST_IDLE);
    scan_start    = 1'b0;
    scan_active   = (state_r == lts_pkg::ST_SCAN);
    mem_we        = 1'b0;
    mem_waddr     = sw_r;
    mem_wdata     = '0;
    sweep_rsp_nxt = sweep_rsp_r;
    sw_nxt        = sw_r;
    q_nxt         = q_r;
    res_nxt       = res_r;
    case (state_r)
      lts_pkg::ST_SWEEP: begin
        mem_we = 1'b1;
        sw_nxt = sw_r + 1'b1;
        if (sweep_end) begin
          sw_nxt        = '0;
          sweep_rsp_nxt = 1'b0;
          res_nxt       = '{link_address: 12'd0, chosen_slot: 10'd0,
                            outcome: lts_pkg::RES_DONE};
        end
      end
      lts_pkg::ST_IDLE: begin
        if (in_acc) begin
          q_nxt   = '{device_addr: in_tdata[48:25], group: in_tdata[24:17],
                      ls3: in_tdata[56:49], is_controller: in_tdata[57]};
          res_nxt = '{link_address: 12'd0, chosen_slot: 10'd0,
                      outcome: lts_pkg::RES_DONE};
          case (opcode)
            lts_pkg::OP_CLEAR: begin
              sweep_rsp_nxt = 1'b1;
              sw_nxt        = '0;
            end
            lts_pkg::OP_FIND: scan_start = 1'b1;
            lts_pkg::OP_WRITE: begin
              // a record without the in-use bit just empties the slot
              mem_we    = slot_ok;
              mem_waddr = in_slot[SW-1:0];
              mem_wdata = {in_flag[lts_pkg::IN_USE_BIT], in_flag, in_tdata[24:17],
                           in_tdata[48:25], in_tdata[56:49]};
            end
            default: ;
          endcase
        end
      end
      lts_pkg::ST_SCAN: begin
        if (scan_done) begin
          res_nxt = scan_res;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (load) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lts_pkg::ST_SWEEP;
      sweep_rsp_r <= 1'b0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_rsp_r <= sweep_rsp_nxt;
      sw_r        <= sw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  lts_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lts_scan #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .active (scan_active),
    .query  (q_r),
    .re     (mem_re),
    .raddr  (mem_raddr),
    .rdata  (mem_rdata),
    .done   (scan_done),
    .result (scan_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.chosen_slot, out_r.link_address};
  assign out_tuser  = out_r.outcome;

`ifndef SYNTH
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lts_pkg::ST_SCAN) |-> !mem_we)
    else $error("table written during a find walk");

  a_find_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (opcode == lts_pkg::OP_FIND)) |=> (state_r == lts_pkg::ST_SCAN))
    else $error("find request did not start a walk");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.outcome == lts_pkg::RES_FULL)) |->
      ((out_r.chosen_slot == lts_pkg::NO_SLOT) && (out_r.link_address == 12'd0)))
    else $error("full result carries a slot");

  a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (state_r == lts_pkg::ST_SCAN))
    else $error("table read outside a find walk");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int SLOT_COUNT     = 512;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_LEN   = 800;
  localparam int CTL_FLAG_BIT   = 6;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [8:0]  slot;
    logic [7:0]  link_flag;
    logic [7:0]  group;
    logic [23:0] device_addr;
    logic [7:0]  ls3;
    logic        is_controller;
  } link_request_t;

  typedef struct packed {
    logic [7:0]  flag;
    logic [7:0]  group;
    logic [23:0] device_addr;
    logic [7:0]  ls3;
  } link_record_t;

  class slot_table_scoreboard;
    bit               slot_used [SLOT_COUNT];
    link_record_t     slot_record [SLOT_COUNT];
    lts_pkg::result_t expected_results [$];
    int unsigned      mismatches;

    function lts_pkg::result_t slot_result(int k, logic [2:0] code);
      lts_pkg::result_t r;
      r.link_address = lts_pkg::TOP_ADDRESS - 12'(k * 8);
      r.chosen_slot  = 10'(k);
      r.outcome      = code;
      return r;
    endfunction

    function void note_request(link_request_t req);
      lts_pkg::result_t exp;
      int      next_free;
      int      gap_start;
      bit      gap_seen;
      bit      found;
      exp.link_address = '0;
      exp.chosen_slot  = '0;
      exp.outcome      = lts_pkg::RES_DONE;
      next_free = 0;
      gap_start = 0;
      gap_seen  = 1'b0;
      found     = 1'b0;
      case (req.opcode)
        lts_pkg::OP_CLEAR: begin
          foreach (slot_used[k]) slot_used[k] = 1'b0;
        end
        lts_pkg::OP_WRITE: begin
          if (req.slot < SLOT_COUNT) begin
            if (req.link_flag[lts_pkg::IN_USE_BIT]) begin
              slot_record[req.slot] = '{req.link_flag, req.group, req.device_addr, req.ls3};
              slot_used[req.slot] = 1'b1;
            end else begin
              // keep the stored record, only drop the in-use mark
              slot_used[req.slot] = 1'b0;
            end
          end
        end
        lts_pkg::OP_FIND: begin
          for (int k = 0; k < SLOT_COUNT && !found; k++) begin
            if (slot_used[k]) begin
              if (k != next_free) begin
                gap_seen  = 1'b1;
                gap_start = next_free;
              end
              if (slot_record[k].device_addr == req.device_addr &&
                  slot_record[k].group == req.group &&
                  slot_record[k].flag[CTL_FLAG_BIT] == req.is_controller &&
                  (req.is_controller || req.ls3 == 8'd0 ||
                   req.ls3 == slot_record[k].ls3)) begin
                found = 1'b1;
                exp   = slot_result(k, lts_pkg::RES_MATCH);
              end else begin
                next_free = k + 1;
              end
            end
          end
          if (!found) begin
            if (gap_seen) begin
              exp = slot_result(gap_start, lts_pkg::RES_GAP);
            end else if (next_free >= SLOT_COUNT) begin
              exp.link_address = '0;
              exp.chosen_slot  = lts_pkg::NO_SLOT;
              exp.outcome      = lts_pkg::RES_FULL;
            end else begin
              exp = slot_result(next_free, lts_pkg::RES_AFTER);
            end
          end
        end
        default: ;
      endcase
      expected_results = {expected_results, exp};
    endfunction

    function void check_result(lts_pkg::result_t got);
      lts_pkg::result_t exp;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: link_address %0d chosen_slot %0d outcome %0d",
               got.link_address, got.chosen_slot, got.outcome);
        mismatches++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.link_address !== exp.link_address) begin
        $error("link_address mismatch: expected %0d, actual %0d",
               exp.link_address, got.link_address);
        mismatches++;
      end
      if (got.chosen_slot !== exp.chosen_slot) begin
        $error("chosen_slot mismatch: expected %0d, actual %0d",
               exp.chosen_slot, got.chosen_slot);
        mismatches++;
      end
      if (got.outcome !== exp.outcome) begin
        $error("outcome mismatch: expected %0d, actual %0d", exp.outcome, got.outcome);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;

  slot_table_scoreboard sb = new();
  bit calm;
  bit hold_off_req;
  int quiet_cycles;

  link_table_slot_finder #(
    .SLOT_COUNT(SLOT_COUNT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 40);
    return $urandom_range(100, 600);
  endfunction

  function automatic logic [23:0] pick_device();
    int r;
    r = $urandom_range(0, 9);
    if (r >= 8) return 24'($urandom);
    case (r % 4)
      0:       return 24'h000000;
      1:       return 24'hffffff;
      2:       return 24'h123456;
      default: return 24'ha5a5a5;
    endcase
  endfunction

  function automatic logic [7:0] pick_group();
    int r;
    r = $urandom_range(0, 9);
    if (r >= 8) return 8'($urandom);
    case (r % 4)
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd7;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [7:0] pick_ls3();
    int r;
    r = $urandom_range(0, 9);
    if (r >= 8) return 8'($urandom);
    case (r % 4)
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd42;
      default: return 8'd255;
    endcase
  endfunction

  function automatic link_request_t make_request(logic [1:0] op, logic [8:0] slot,
                                                 logic [7:0] flag, logic [7:0] grp,
                                                 logic [23:0] dev, logic [7:0] l3,
                                                 logic ctl);
    link_request_t q;
    q.opcode        = op;
    q.slot          = slot;
    q.link_flag     = flag;
    q.group         = grp;
    q.device_addr   = dev;
    q.ls3           = l3;
    q.is_controller = ctl;
    return q;
  endfunction

  function automatic link_request_t random_request(int span);
    link_request_t q;
    int            r;
    q = make_request(lts_pkg::OP_FIND, 9'($urandom_range(0, span)),
                     8'($urandom_range(0, 255)), pick_group(), pick_device(), pick_ls3(),
                     1'($urandom_range(0, 1)));
    r = $urandom_range(0, 99);
    if (r < 2) begin
      q.opcode = lts_pkg::OP_CLEAR;
    end else if (r < 4) begin
      q.opcode = OP_RESERVED;
    end else if (r < 52) begin
      q.opcode = lts_pkg::OP_WRITE;
      if ($urandom_range(0, 99) < 85) q.link_flag[lts_pkg::IN_USE_BIT] = 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      q.ls3 = 8'd0;
    end
    return q;
  endfunction

  task automatic send_request(link_request_t req);
    int n;
    n = idle_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, req.is_controller, req.ls3, req.device_addr, req.group,
                  req.link_flag, req.slot};
    in_tuser  <= req.opcode;
    do @(posedge clk); while (!in_tready);
    sb.note_request(req);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    lts_pkg::result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.link_address = out_tdata[11:0];
        got.chosen_slot  = out_tdata[21:12];
        got.outcome      = out_tuser;
        sb.check_result(got);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int span;
    int r;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= lts_pkg::OP_CLEAR;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, then reuse by controller bit and ls3
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd0, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd511, 8'hff, 8'd255, 24'hffffff, 8'd255,
                              1'b1));
    send_request(make_request(lts_pkg::OP_WRITE, 9'd0, 8'hc0, 8'd255, 24'hffffff, 8'd255,
                              1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd255, 24'hffffff, 8'd17, 1'b1));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd255, 24'hffffff, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_WRITE, 9'd2, 8'h80, 8'd0, 24'h000000, 8'h5a, 1'b1));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd0, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd0, 24'h000000, 8'h5a, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd0, 24'h000000, 8'h11, 1'b0));
    send_request(make_request(lts_pkg::OP_WRITE, 9'd511, 8'hff, 8'd7, 24'h123456, 8'd1, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd7, 24'h123456, 8'd0, 1'b1));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd8, 24'h123456, 8'd0, 1'b1));
    // drop the in-use mark of slot 2 but keep its record
    send_request(make_request(lts_pkg::OP_WRITE, 9'd2, 8'h7f, 8'd0, 24'h000000, 8'h5a, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd0, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(OP_RESERVED, 9'd2, 8'hff, 8'd0, 24'h000000, 8'h5a, 1'b1));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd0, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_WRITE, 9'd2, 8'h80, 8'd1, 24'ha5a5a5, 8'd42, 1'b0));
    send_request(make_request(lts_pkg::OP_WRITE, 9'd2, 8'h00, 8'd1, 24'ha5a5a5, 8'd42, 1'b0));
    send_request(make_request(lts_pkg::OP_CLEAR, 9'd0, 8'h00, 8'd0, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd0, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_WRITE, 9'd1, 8'h80, 8'd1, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd1, 24'h000001, 8'd0, 1'b0));
    wait_drained();

    // fill every slot, then open holes at the top and in the middle
    for (int k = 0; k < SLOT_COUNT; k++) begin
      send_request(make_request(lts_pkg::OP_WRITE, 9'(k), 8'($urandom_range(0, 255)) | 8'h80,
                                pick_group(), pick_device(), pick_ls3(), 1'b0));
    end
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd3, 24'h5a5a5a, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd3, 24'h5a5a5a, 8'd9, 1'b1));
    repeat (4) send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, pick_group(),
                                         pick_device(), pick_ls3(),
                                         1'($urandom_range(0, 1))));
    send_request(make_request(lts_pkg::OP_WRITE, 9'd511, 8'h00, 8'd0, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd3, 24'h5a5a5a, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_WRITE, 9'd300, 8'h40, 8'd0, 24'h000000, 8'd0, 1'b0));
    send_request(make_request(lts_pkg::OP_FIND, 9'd0, 8'h00, 8'd3, 24'h5a5a5a, 8'd0, 1'b1));
    send_request(make_request(lts_pkg::OP_CLEAR, 9'd0, 8'h00, 8'd0, 24'h000000, 8'd0, 1'b0));
    wait_drained();

    // hold the result channel off while writes keep coming
    hold_off_req = 1'b1;
    repeat (30) send_request(make_request(lts_pkg::OP_WRITE, 9'($urandom_range(0, 15)),
                                          8'($urandom_range(0, 255)) | 8'h80, pick_group(),
                                          pick_device(), pick_ls3(), 1'b0));
    wait_drained();

    repeat (12) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      span = (r < 60) ? 15 : (r < 85) ? 63 : SLOT_COUNT - 1;
      repeat (50) send_request(random_request(span));
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (600) @(posedge clk);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lts_pkg.sv
rtl/core/lts_mem.sv
rtl/core/lts_scan.sv
rtl/core/link_table_slot_finder.sv
tb/testbench.sv
